>>> design/assert_macros.svh
// Assertion macros for the design files; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checks a property at every rising clock edge outside reset.
`define ASSERT_SYNC(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Checks a property at every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);
`endif

>>> design/mvd_pkg.sv
// Types, codes and index arithmetic for the mesh vertex deduplicator.
package mvd_pkg;

   localparam int unsigned CFG_WIDTH = 23;
   localparam int unsigned IDX_WIDTH = 24;

   typedef enum logic {
      REG_NUM_POSITIONS = 1'b0,
      REG_NUM_TEXCOORDS = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [15:0]        group_id;
      logic signed [23:0] pos_a;
      logic signed [23:0] pos_b;
      logic signed [23:0] pos_c;
      logic signed [23:0] tex_a;
      logic signed [23:0] tex_b;
      logic signed [23:0] tex_c;
   } req_word_type;

   typedef struct packed {
      logic [23:0]        out_vertex;
      logic               is_new;
      logic [22:0]        src_position;
      logic signed [23:0] src_texcoord;
      logic               overflow;
      logic               last_of_face;
   } rsp_word_type;

   typedef struct packed {
      logic        valid;
      logic        hit;
      logic [22:0] pkey;
      logic [23:0] tkey;
      logic [23:0] vnum;
   } query_type;

   typedef struct packed {
      logic        en;
      logic [22:0] pkey;
      logic [23:0] tkey;
      logic [23:0] vnum;
   } entry_write_type;

   // A negative index counts back from the total: total + idx + 1.
   function automatic logic [24:0] resolve_index(logic [23:0] idx, logic [22:0] total);
      logic [24:0] r;
      if (idx[23]) begin
         r = {2'b00, total} + {idx[23], idx} + 25'd1;
      end else begin
         r = {1'b0, idx};
      end
      return r;
   endfunction

endpackage

>>> design/mvd_cell.sv
// One cache entry of the search chain; the query moves one cell per cycle.
module mvd_cell #(
   parameter int unsigned CACHE_DEPTH = 1024,
   parameter int unsigned CELL_INDEX  = 0
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             use_tex,
   input  logic [$clog2(CACHE_DEPTH+1)-1:0] entry_count,
   input  logic [$clog2(CACHE_DEPTH)-1:0]   write_index,
   input  mvd_pkg::entry_write_type         write_bus,
   input  mvd_pkg::query_type               query_in,
   output mvd_pkg::query_type               query_out
);
   import mvd_pkg::*;

   localparam int unsigned CW = $clog2(CACHE_DEPTH + 1);
   localparam int unsigned AW = $clog2(CACHE_DEPTH);

   logic [22:0] pos_ff;
   logic [23:0] tex_ff;
   logic [23:0] vnum_ff;
   query_type   query_ff;
   query_type   query_in_q;
   logic        match;

   always_ff @(posedge clock) begin
      if (write_bus.en && write_index == AW'(CELL_INDEX)) begin
         pos_ff  <= write_bus.pkey;
         tex_ff  <= write_bus.tkey;
         vnum_ff <= write_bus.vnum;
      end
   end

   always_comb begin
      match = query_in.valid && !query_in.hit && (CW'(CELL_INDEX) < entry_count)
              && query_in.pkey == pos_ff && (!use_tex || query_in.tkey == tex_ff);
      query_in_q = query_in;
      if (match) begin
         query_in_q.hit  = 1'b1;
         query_in_q.vnum = vnum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         query_ff <= '0;
      end else begin
         query_ff <= query_in_q;
      end
   end

   assign query_out = query_ff;

endmodule

>>> design/mesh_vertex_dedup.sv
// Top level of the mesh vertex deduplicator: controller and the chain of cache cells.
//
//  port group   direction  handshake           word
//  req_         in         req_valid/req_stall req_word (one triangle)
//  rsp_         out        rsp_valid/rsp_stall rsp_word (one corner)
//  csr_         in         csr_we              csr_index, csr_wdata
//
// For each emitted corner the controller launches its key in S_NEXT, waits in S_SEARCH while
// the key walks the chain one cell per cycle, and passes the word on in S_EMIT.
// After a triangle is accepted, req_stall stays high until the controller is back in S_IDLE;
// skipped corners shorten this, and a degenerate triangle goes from S_NEXT straight to S_IDLE.
// Reset clears the counters, the group tracking and the controller; cache entries
// are only read below the entry count and need no clearing. A stalled result word
// holds the controller in its emit state, which lengthens the triangle by those cycles.
module mesh_vertex_dedup #(
   parameter int unsigned CACHE_DEPTH = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  mvd_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output mvd_pkg::rsp_word_type rsp_word,
   input  logic                  csr_we,
   input  mvd_pkg::csr_index_type csr_index,
   input  logic [22:0]           csr_wdata
);
   import mvd_pkg::*;

   `include "assert_macros.svh"

   localparam int unsigned CW = $clog2(CACHE_DEPTH + 1);
   localparam int unsigned AW = $clog2(CACHE_DEPTH);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_NEXT   = 4'b0010,
      S_SEARCH = 4'b0100,
      S_EMIT   = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [22:0]      num_pos_ff, num_tex_ff;
   logic [CW-1:0]    entry_count_ff, entry_count_in;
   logic [IDX_WIDTH-1:0] next_vertex_ff, next_vertex_in;
   logic [15:0]      group_ff, group_in;
   logic             seen_ff, seen_in;
   logic [2:0]       mask_ff, mask_in;
   logic [1:0]       sel_ff, sel_in;
   logic [22:0]      pos_ff [3];
   logic [23:0]      tex_ff [3];
   logic [22:0]      pos_in [3];
   logic [23:0]      tex_in [3];
   logic [2:0]       ok_in;
   rsp_word_type     res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_word_type     rsp_word_ff, rsp_word_in;

   logic             use_tex;
   logic             req_take;
   logic             out_free;
   logic [1:0]       sel;
   logic [2:0]       sel_bit;
   logic [24:0]      pr, tr;
   query_type        chain [CACHE_DEPTH+1];
   entry_write_type  wbus;
   logic [AW-1:0]    widx;
   logic [23:0]      pos_raw [3];
   logic [23:0]      tex_raw [3];

   assign use_tex   = num_tex_ff != 23'd0;
   assign req_stall = state_ff != S_IDLE;
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign widx      = entry_count_ff[AW-1:0];

   assign pos_raw[0] = req_word.pos_a;
   assign pos_raw[1] = req_word.pos_b;
   assign pos_raw[2] = req_word.pos_c;
   assign tex_raw[0] = req_word.tex_a;
   assign tex_raw[1] = req_word.tex_b;
   assign tex_raw[2] = req_word.tex_c;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pr = resolve_index(pos_raw[i], num_pos_ff);
         tr = use_tex ? resolve_index(tex_raw[i], num_tex_ff) : 25'd0;
         ok_in[i]  = !pr[24] && (pr[23:0] < {1'b0, num_pos_ff});
         pos_in[i] = pr[22:0];
         tex_in[i] = tr[23:0];
      end
   end

   always_comb begin
      if (mask_ff[0]) begin
         sel = 2'd0;
      end else if (mask_ff[1]) begin
         sel = 2'd1;
      end else begin
         sel = 2'd2;
      end
      sel_bit = 3'b001 << sel_ff;
   end

   assign chain[0].valid = state_ff == S_NEXT && mask_ff != 3'b000;
   assign chain[0].hit   = 1'b0;
   assign chain[0].pkey  = pos_ff[sel];
   assign chain[0].tkey  = tex_ff[sel];
   assign chain[0].vnum  = 24'd0;

   for (genvar g = 0; g < CACHE_DEPTH; g++) begin : g_cell
      mvd_cell #(
         .CACHE_DEPTH(CACHE_DEPTH),
         .CELL_INDEX (g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .use_tex    (use_tex),
         .entry_count(entry_count_ff),
         .write_index(widx),
         .write_bus  (wbus),
         .query_in   (chain[g]),
         .query_out  (chain[g+1])
      );
   end

   always_comb begin
      state_in       = state_ff;
      entry_count_in = entry_count_ff;
      next_vertex_in = next_vertex_ff;
      group_in       = group_ff;
      seen_in        = seen_ff;
      mask_in        = mask_ff;
      sel_in         = sel_ff;
      res_in         = res_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_word_in    = rsp_word_ff;
      wbus           = '0;
      wbus.pkey      = pos_ff[sel_ff];
      wbus.tkey      = tex_ff[sel_ff];
      wbus.vnum      = next_vertex_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (!seen_ff || req_word.group_id != group_ff) begin
                  group_in       = req_word.group_id;
                  seen_in        = 1'b1;
                  entry_count_in = '0;
               end
               if (req_word.pos_a == req_word.pos_b || req_word.pos_a == req_word.pos_c
                   || req_word.pos_b == req_word.pos_c) begin
                  mask_in = 3'b000;
               end else begin
                  mask_in = ok_in;
               end
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (mask_ff == 3'b000) begin
               state_in = S_IDLE;
            end else begin
               sel_in   = sel;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (chain[CACHE_DEPTH].valid) begin
               res_in.src_position = pos_ff[sel_ff];
               res_in.src_texcoord = tex_ff[sel_ff];
               res_in.last_of_face = (mask_ff & ~sel_bit) == 3'b000;
               res_in.is_new       = 1'b0;
               res_in.overflow     = 1'b0;
               if (chain[CACHE_DEPTH].hit) begin
                  res_in.out_vertex = chain[CACHE_DEPTH].vnum;
               end else if (next_vertex_ff == {IDX_WIDTH{1'b1}}) begin
                  res_in.out_vertex = next_vertex_ff;
                  res_in.overflow   = 1'b1;
               end else begin
                  res_in.out_vertex = next_vertex_ff;
                  res_in.is_new     = 1'b1;
                  next_vertex_in    = next_vertex_ff + IDX_WIDTH'(1);
                  if (entry_count_ff < CW'(CACHE_DEPTH)) begin
                     wbus.en        = 1'b1;
                     entry_count_in = entry_count_ff + CW'(1);
                  end else begin
                     res_in.overflow = 1'b1;
                  end
               end
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = res_ff;
               mask_in      = mask_ff & ~sel_bit;
               state_in     = S_NEXT;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         num_pos_ff     <= '0;
         num_tex_ff     <= '0;
         entry_count_ff <= '0;
         next_vertex_ff <= '0;
         group_ff       <= '0;
         seen_ff        <= 1'b0;
         mask_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         next_vertex_ff <= next_vertex_in;
         group_ff       <= group_in;
         seen_ff        <= seen_in;
         mask_ff        <= mask_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_we && csr_index == REG_NUM_POSITIONS) begin
            num_pos_ff <= csr_wdata;
         end
         if (csr_we && csr_index == REG_NUM_TEXCOORDS) begin
            num_tex_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      sel_ff      <= sel_in;
      res_ff      <= res_in;
      rsp_word_ff <= rsp_word_in;
      if (req_take) begin
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= pos_in[i];
            tex_ff[i] <= tex_in[i];
         end
      end
   end

   `ASSERT_SYNC(a_count_bound, entry_count_ff <= CW'(CACHE_DEPTH), "entry count beyond depth")
   `ASSERT_SYNC(a_tail_in_search, chain[CACHE_DEPTH].valid |-> state_ff == S_SEARCH, "stray query")
   `ASSERT_SYNC(a_counter_mono, ##1 (next_vertex_ff >= $past(next_vertex_ff)), "counter went back")
   `ASSERT_SYNC(a_emit_free, (state_ff == S_EMIT && out_free) |=> rsp_valid_ff, "result lost")

endmodule

>>> sim/tb_mesh_vertex_dedup.sv
// Self-checking testbench for the mesh vertex deduplicator with a predicting scoreboard.
module tb_mesh_vertex_dedup;
   timeunit 1ns;
   timeprecision 1ps;
   import mvd_pkg::*;

   localparam int DEPTH = 1024;
   localparam int CORNER_CYCLES = 3 * (DEPTH + 3) + 16;
   localparam int IDLE_LIMIT = 40000;

   class vertex_scoreboard;
      bit [22:0] num_pos;
      bit [22:0] num_tex;
      bit [23:0] key_pos[DEPTH];
      bit [23:0] key_tex[DEPTH];
      bit [23:0] key_vnum[DEPTH];
      int unsigned entries;
      longint next_num;
      bit [15:0] cur_group;
      bit group_valid;
      rsp_word_type expected_words[$];
      int errors;

      task report(string msg);
         $display("MISMATCH: %s", msg);
         errors++;
      endtask

      function longint resolve(logic signed [23:0] idx, bit [22:0] total);
         longint v;
         v = longint'(idx);
         if (v < 0) begin
            v = longint'(total) + v + 1;
         end
         return v;
      endfunction

      function void note_triangle(req_word_type w);
         logic signed [23:0] pos[3];
         logic signed [23:0] tex[3];
         longint p, t;
         bit use_tex, hit;
         int produced;
         rsp_word_type r;
         pos[0] = w.pos_a; pos[1] = w.pos_b; pos[2] = w.pos_c;
         tex[0] = w.tex_a; tex[1] = w.tex_b; tex[2] = w.tex_c;
         produced = 0;
         if (!group_valid || w.group_id != cur_group) begin
            cur_group = w.group_id;
            group_valid = 1;
            entries = 0;
         end
         if (pos[0] == pos[1] || pos[0] == pos[2] || pos[1] == pos[2]) return;
         use_tex = num_tex != 0;
         for (int i = 0; i < 3; i++) begin
            p = resolve(pos[i], num_pos);
            t = use_tex ? resolve(tex[i], num_tex) : 0;
            if (p < 0 || p >= longint'(num_pos)) continue;
            r = '0;
            hit = 0;
            for (int j = 0; j < entries; j++) begin
               if (key_pos[j] == p[23:0] && (!use_tex || key_tex[j] == t[23:0])) begin
                  r.out_vertex = key_vnum[j];
                  hit = 1;
                  break;
               end
            end
            if (!hit) begin
               if (next_num >= 64'hFFFFFF) begin
                  r.out_vertex = 24'hFFFFFF;
                  r.overflow = 1;
               end else begin
                  r.out_vertex = next_num[23:0];
                  r.is_new = 1;
                  if (entries < DEPTH) begin
                     key_pos[entries] = p[23:0];
                     key_tex[entries] = t[23:0];
                     key_vnum[entries] = next_num[23:0];
                     entries++;
                  end else begin
                     r.overflow = 1;
                  end
                  next_num++;
               end
            end
            r.src_position = p[22:0];
            r.src_texcoord = t[23:0];
            expected_words.insert(expected_words.size(), r);
            produced++;
         end
         if (produced > 0) expected_words[$].last_of_face = 1;
      endfunction

      task check_corner(rsp_word_type got);
         rsp_word_type e;
         if (expected_words.size() == 0) begin
            report($sformatf("unexpected word %h", got));
            return;
         end
         e = expected_words.pop_front();
         if (got.out_vertex !== e.out_vertex)
            report($sformatf("out_vertex %h, expected %h", got.out_vertex, e.out_vertex));
         if (got.is_new !== e.is_new)
            report($sformatf("is_new %b, expected %b", got.is_new, e.is_new));
         if (got.src_position !== e.src_position)
            report($sformatf("src_position %h, expected %h", got.src_position,
                             e.src_position));
         if (got.src_texcoord !== e.src_texcoord)
            report($sformatf("src_texcoord %h, expected %h", got.src_texcoord,
                             e.src_texcoord));
         if (got.overflow !== e.overflow)
            report($sformatf("overflow %b, expected %b", got.overflow, e.overflow));
         if (got.last_of_face !== e.last_of_face)
            report($sformatf("last_of_face %b, expected %b", got.last_of_face,
                             e.last_of_face));
      endtask
   endclass

   logic clock = 0;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_word_type req_word;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic csr_we;
   csr_index_type csr_index;
   logic [22:0] csr_wdata;

   vertex_scoreboard sb = new();
   int idle_cycles;
   int cycle_count;
   int burst_left;
   bit [15:0] group_now;

   mesh_vertex_dedup u_top (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      case ((cycle_count / 600) % 4)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom % 4) == 0;
         2: rsp_stall <= ($urandom % 4) != 0;
         default: rsp_stall <= (cycle_count % 7) < 3;
      endcase
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) sb.note_triangle(req_word);
      if (!reset && rsp_valid && !rsp_stall) sb.check_corner(rsp_word);
      if (!reset && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
                     || csr_we))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic wait_drained();
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (CORNER_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [22:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_NUM_POSITIONS) sb.num_pos = value;
      else sb.num_tex = value;
      @(posedge clock);
   endtask

   task automatic send_triangle(req_word_type w);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 6);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic logic signed [23:0] pick_index(bit [22:0] total);
      longint span, v;
      span = total > 40 ? 40 : total;
      case ($urandom % 8)
         0, 1, 2, 3: v = $urandom_range(0, span);
         4, 5: v = -longint'($urandom_range(1, span + 2));
         6: v = longint'(total) - 1 + $urandom_range(0, 3);
         default: v = $urandom;
      endcase
      return v[23:0];
   endfunction

   function automatic req_word_type make_triangle(bit [22:0] np, bit [22:0] nt);
      req_word_type w;
      if ($urandom % 12 == 0) group_now = 16'($urandom);
      w.group_id = group_now;
      w.pos_a = pick_index(np);
      w.pos_b = pick_index(np);
      w.pos_c = pick_index(np);
      w.tex_a = pick_index(nt);
      w.tex_b = pick_index(nt);
      w.tex_c = pick_index(nt);
      if ($urandom % 10 == 0) w.pos_c = w.pos_a;
      return w;
   endfunction

   function automatic req_word_type tri_word(bit [15:0] g, int a, int b, int c,
                                             int ta, int tb, int tc);
      req_word_type w;
      w.group_id = g;
      w.pos_a = 24'(a); w.pos_b = 24'(b); w.pos_c = 24'(c);
      w.tex_a = 24'(ta); w.tex_b = 24'(tb); w.tex_c = 24'(tc);
      return w;
   endfunction

   task automatic run_phase(bit [22:0] np, bit [22:0] nt, int count);
      req_valid <= 1'b0;
      burst_left = 0;
      wait_drained();
      write_reg(REG_NUM_POSITIONS, np);
      write_reg(REG_NUM_TEXCOORDS, nt);
      for (int i = 0; i < count; i++) send_triangle(make_triangle(np, nt));
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_word <= '0;
      csr_we <= 1'b0;
      csr_index <= REG_NUM_POSITIONS;
      csr_wdata <= '0;
      burst_left = 0;
      group_now = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_reg(REG_NUM_POSITIONS, 23'd16);
      write_reg(REG_NUM_TEXCOORDS, 23'd8);
      send_triangle(tri_word(16'd0, 0, 1, 2, 0, 1, 2));
      send_triangle(tri_word(16'd0, 2, 1, 0, 0, 1, 2));
      send_triangle(tri_word(16'd0, 2, 1, 0, 3, 1, -1));
      send_triangle(tri_word(16'd0, -1, -2, -16, -8, -9, 7));
      send_triangle(tri_word(16'd0, 15, 16, -17, 100, -100, 8));
      send_triangle(tri_word(16'd0, 8388607, -8388608, 3, 8388607, -8388608, 0));
      send_triangle(tri_word(16'd5, 1, 1, 2, 0, 0, 0));
      send_triangle(tri_word(16'd5, 0, 1, 2, 0, 1, 2));
      send_triangle(tri_word(16'd65535, 4, 5, 4, 0, 0, 0));
      send_triangle(tri_word(16'd65535, 4, 5, 6, -8388608, 8388607, -1));
      send_triangle(tri_word(16'd65535, -17, 20, 30, 0, 0, 0));
      send_triangle(tri_word(16'd5, 0, 1, 2, 0, 1, 2));
      req_valid <= 1'b0;
      burst_left = 0;
      wait_drained();
      write_reg(REG_NUM_TEXCOORDS, 23'd0);
      send_triangle(tri_word(16'd7, 3, 4, 5, 1, 2, 3));
      send_triangle(tri_word(16'd7, 5, 4, 3, 6, 7, 0));
      send_triangle(tri_word(16'd7, -1, 2, 3, 0, 0, 0));
      for (int i = 0; i < 25; i++) send_triangle(make_triangle(23'd16, 23'd0));

      run_phase(23'd40, 23'd12, 35);
      run_phase(23'd8388607, 23'd8388607, 30);
      run_phase(23'd0, 23'd0, 8);
      run_phase(23'd1, 23'd3, 15);
      run_phase(23'd200, 23'd4, 35);
      run_phase(23'd25, 23'd0, 25);

      req_valid <= 1'b0;
      wait_drained();
      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

>>> filelist.f
+incdir+design
design/mvd_pkg.sv
design/mvd_cell.sv
design/mesh_vertex_dedup.sv
sim/tb_mesh_vertex_dedup.sv
